FILE: hdl/bdlp_pkg.sv
// Shared types and constants for the push-button debounce / long-press / pulse core.
// Used by button_debounce_longpress_pulse_core; depends on nothing else.

package bdlp_pkg;

   // Field widths
   localparam int DEBOUNCE_W  = 10;
   localparam int LONGPRESS_W = 16;
   localparam int PULSE_W     = 16;
   localparam int HELD_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // Stream word layout
   localparam int REQ_TDATA_W = 24;   // pin_level + pulse_ms = 17 bits, padded to bytes
   localparam int RSP_TDATA_W = 40;   // press_duration + drive_enable + drive_level = 34 bits
   localparam int RSP_TUSER_W = 2;

   // Register reset values
   localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RST     = DEBOUNCE_W'(50);
   localparam logic [LONGPRESS_W-1:0] LONGPRESS_RST    = LONGPRESS_W'(1000);
   localparam logic                   ACTIVE_LEVEL_RST = 1'b0;

   // Event codes
   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2,
      EV_LONG    = 2'd3
   } event_type;

   // Request kinds
   typedef enum logic {
      FUNC_TICK  = 1'b0,
      FUNC_PULSE = 1'b1
   } func_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEBOUNCE     = 2'd0,
      REG_LONGPRESS    = 2'd1,
      REG_ACTIVE_LEVEL = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_idx_type;

endpackage

FILE: hdl/button_debounce_longpress_pulse_core.sv
// Push-button front end: debounce, press / release / long-press events, output pulse.
// Depends on bdlp_pkg for widths, event codes and register indexes.
// Single module, all state updates done in the accept cycle.

// Each request word is either a one-millisecond tick with a pin sample (tuser 0) or a
// pulse start (tuser 1); every request produces exactly one response word in the
// following cycle. The block takes one word per clock: the state update is a single pass of
// counter decrements and compares, and the response register is the only stage, so
// req_tready stays high unless the response register is full and rsp_tready is low.
// Configuration writes are always taken (csr_ready is tied high) and should only be
// issued while no response is pending.

module button_debounce_longpress_pulse_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bdlp_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [0] pin_level, [16:1] pulse_ms
   input  logic                                 req_tuser,  // [0] func
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bdlp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [31:0] press_duration,
                                                            // [32] drive_enable, [33] drive_level
   output logic [bdlp_pkg::RSP_TUSER_W-1:0]     rsp_tuser,  // [1:0] event_code
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int DW = bdlp_pkg::DEBOUNCE_W;
   localparam int LW = bdlp_pkg::LONGPRESS_W;
   localparam int HW = bdlp_pkg::HELD_W;

   // Configuration registers
   logic [DW-1:0] debounce_ms_ff;
   logic [LW-1:0] long_press_ms_ff;
   logic          active_level_ff;

   // Block state
   logic          last_level_ff,   last_level_in;
   logic [DW-1:0] deb_left_ff,     deb_left_in;
   logic          deb_run_ff,      deb_run_in;
   logic [LW-1:0] sh_left_ff,      sh_left_in;
   logic          sh_run_ff,       sh_run_in;
   logic          pulse_ff,        pulse_in;
   logic [HW-1:0] held_ff,         held_in;

   // Response register
   logic                    rsp_valid_ff;
   bdlp_pkg::event_type     rsp_event_ff,  rsp_event_in;
   logic [HW-1:0]           rsp_dur_ff,    rsp_dur_in;
   logic                    rsp_den_ff;
   logic                    rsp_dlev_ff;

   // Request fields
   logic                    pin_level;
   logic [bdlp_pkg::PULSE_W-1:0] pulse_ms;
   bdlp_pkg::func_type      func;

   logic req_accept;
   logic deb_fire;
   logic sh_fire;

   assign pin_level = req_tdata[0];
   assign pulse_ms  = req_tdata[bdlp_pkg::PULSE_W:1];
   assign func      = bdlp_pkg::func_type'(req_tuser);

   // Take a new word whenever the response register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff   <= bdlp_pkg::DEBOUNCE_RST;
         long_press_ms_ff <= bdlp_pkg::LONGPRESS_RST;
         active_level_ff  <= bdlp_pkg::ACTIVE_LEVEL_RST;
      end else if (csr_valid) begin
         unique case (bdlp_pkg::reg_idx_type'(csr_index))
            bdlp_pkg::REG_DEBOUNCE:     debounce_ms_ff   <= csr_data[DW-1:0];
            bdlp_pkg::REG_LONGPRESS:    long_press_ms_ff <= csr_data[LW-1:0];
            bdlp_pkg::REG_ACTIVE_LEVEL: active_level_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Countdown expiry: a count of one or zero runs out on this tick
   assign deb_fire = deb_run_ff && (deb_left_ff <= DW'(1));
   assign sh_fire  = sh_run_ff  && (sh_left_ff  <= LW'(1));

   // Next state and result for one word
   always_comb begin
      last_level_in = last_level_ff;
      deb_left_in   = deb_left_ff;
      deb_run_in    = deb_run_ff;
      sh_left_in    = sh_left_ff;
      sh_run_in     = sh_run_ff;
      pulse_in      = pulse_ff;
      held_in       = held_ff;
      rsp_event_in  = bdlp_pkg::EV_NONE;
      rsp_dur_in    = '0;

      if (func == bdlp_pkg::FUNC_PULSE) begin
         // start or restart the pulse on the shared countdown
         pulse_in   = 1'b1;
         sh_left_in = pulse_ms;
         sh_run_in  = 1'b1;
      end else begin
         held_in = held_ff + HW'(1);

         // advance running countdowns
         if (deb_run_ff) begin
            deb_left_in = deb_fire ? '0 : deb_left_ff - DW'(1);
            if (deb_fire) begin
               deb_run_in = 1'b0;
            end
         end
         if (sh_run_ff) begin
            sh_left_in = sh_fire ? '0 : sh_left_ff - LW'(1);
         end

         // debounce decision wins over shared expiry
         if (deb_fire) begin
            if (pin_level == active_level_ff) begin
               held_in      = '0;
               rsp_event_in = bdlp_pkg::EV_PRESS;
               sh_left_in   = long_press_ms_ff;
               sh_run_in    = 1'b1;
            end else begin
               rsp_event_in = bdlp_pkg::EV_RELEASE;
               rsp_dur_in   = held_ff + HW'(1);
               sh_left_in   = '0;
               sh_run_in    = 1'b0;
            end
         end else if (sh_fire) begin
            if (pulse_ff) begin
               pulse_in  = 1'b0;
               sh_run_in = 1'b0;
            end else begin
               rsp_event_in = bdlp_pkg::EV_LONG;
               sh_left_in   = long_press_ms_ff;
            end
         end

         // restart debounce on an edge outside a pulse
         if (!pulse_in && (pin_level != last_level_ff)) begin
            deb_left_in = debounce_ms_ff;
            deb_run_in  = 1'b1;
         end
         last_level_in = pin_level;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         deb_left_ff   <= '0;
         deb_run_ff    <= 1'b0;
         sh_left_ff    <= '0;
         sh_run_ff     <= 1'b0;
         pulse_ff      <= 1'b0;
         held_ff       <= '0;
      end else if (req_accept) begin
         last_level_ff <= last_level_in;
         deb_left_ff   <= deb_left_in;
         deb_run_ff    <= deb_run_in;
         sh_left_ff    <= sh_left_in;
         sh_run_ff     <= sh_run_in;
         pulse_ff      <= pulse_in;
         held_ff       <= held_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload, loaded with each accepted word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_event_ff <= rsp_event_in;
         rsp_dur_ff   <= rsp_dur_in;
         rsp_den_ff   <= pulse_in;
         rsp_dlev_ff  <= pulse_in & active_level_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tdata  = {{(bdlp_pkg::RSP_TDATA_W - HW - 2){1'b0}},
                        rsp_dlev_ff, rsp_den_ff, rsp_dur_ff};

   // Idle countdowns rest at zero
   a_deb_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !deb_run_ff |-> (deb_left_ff == '0))
      else $error("debounce countdown not zero while stopped");

   a_sh_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !sh_run_ff |-> (sh_left_ff == '0))
      else $error("shared countdown not zero while stopped");

   // Only a release carries a held time
   a_dur_release_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_ff != bdlp_pkg::EV_RELEASE)) |-> (rsp_dur_ff == '0))
      else $error("press duration on non-release event");

   // A driven level implies the drive is enabled
   a_drive_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dlev_ff) |-> rsp_den_ff)
      else $error("drive level set without drive enable");

   // A stalled response blocks new words
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_accept)
      else $error("request accepted over a stalled response");

endmodule

FILE: verif/bdlp_event_checker.sv
// Event checker for the push-button debounce / long-press / pulse core.
// Watches the request, response and register channels, predicts each response word
// from its own model of the button logic and compares field by field. Needs bdlp_pkg.

module bdlp_event_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [bdlp_pkg::REQ_TDATA_W-1:0] req_tdata,   // [0] pin_level, [16:1] pulse_ms
   input  logic                             req_tuser,   // [0] func
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [bdlp_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] press_duration,
                                                         // [32] drive_enable,
                                                         // [33] drive_level
   input  logic [bdlp_pkg::RSP_TUSER_W-1:0] rsp_tuser,   // [1:0] event_code
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatch_count,
   output int                               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      bdlp_pkg::event_type         ev;
      logic [bdlp_pkg::HELD_W-1:0] held;
      logic                        drive_en;
      logic                        drive_lvl;
   } button_result_type;

   // register copies
   logic [bdlp_pkg::DEBOUNCE_W-1:0]  debounce_cfg;
   logic [bdlp_pkg::LONGPRESS_W-1:0] longpress_cfg;
   logic                             active_cfg;

   // button state
   logic                             prev_level;
   logic [bdlp_pkg::DEBOUNCE_W-1:0]  settle_left;
   logic                             settle_run;
   logic [bdlp_pkg::PULSE_W-1:0]     hold_left;
   logic                             hold_run;
   logic                             pulse_on;
   logic [bdlp_pkg::HELD_W-1:0]      held_ticks;

   button_result_type expected_events[$];
   button_result_type want, got;
   int                rsp_count;

   // Advance the button state by one word and return the response it causes.
   function automatic button_result_type predict_button_step(bdlp_pkg::func_type f,
                                                             logic lvl,
                                                             logic [bdlp_pkg::PULSE_W-1:0] plen);
      button_result_type r;
      logic settle_fire;
      logic hold_fire;
      r = '0;
      r.ev = bdlp_pkg::EV_NONE;
      if (f == bdlp_pkg::FUNC_PULSE) begin
         // start or restart a pulse; no time passes
         pulse_on  = 1'b1;
         hold_left = plen;
         hold_run  = 1'b1;
      end else begin
         settle_fire = 1'b0;
         hold_fire   = 1'b0;
         held_ticks  = held_ticks + 1'b1;
         // count both timers down; a load of zero expires like a load of one
         if (settle_run) begin
            if (settle_left <= 1) begin
               settle_left = '0;
               settle_run  = 1'b0;
               settle_fire = 1'b1;
            end else begin
               settle_left = settle_left - 1'b1;
            end
         end
         if (hold_run) begin
            if (hold_left <= 1) begin
               hold_left = '0;
               hold_fire = 1'b1;
            end else begin
               hold_left = hold_left - 1'b1;
            end
         end
         // a debounce decision takes priority over the shared timer
         if (settle_fire) begin
            if (lvl == active_cfg) begin
               held_ticks = '0;
               r.ev       = bdlp_pkg::EV_PRESS;
               hold_left  = longpress_cfg;
               hold_run   = 1'b1;
            end else begin
               r.ev      = bdlp_pkg::EV_RELEASE;
               r.held    = held_ticks;
               hold_left = '0;
               hold_run  = 1'b0;
            end
         end else if (hold_fire) begin
            if (pulse_on) begin
               pulse_on = 1'b0;
               hold_run = 1'b0;
            end else begin
               r.ev      = bdlp_pkg::EV_LONG;
               hold_left = longpress_cfg;
            end
         end
         // restart debounce on an edge unless a pulse drives the pin
         if (!pulse_on && lvl != prev_level) begin
            settle_left = debounce_cfg;
            settle_run  = 1'b1;
         end
         prev_level = lvl;
      end
      r.drive_en  = pulse_on;
      r.drive_lvl = pulse_on & active_cfg;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         debounce_cfg   = bdlp_pkg::DEBOUNCE_RST;
         longpress_cfg  = bdlp_pkg::LONGPRESS_RST;
         active_cfg     = bdlp_pkg::ACTIVE_LEVEL_RST;
         prev_level     = 1'b0;
         settle_left    = '0;
         settle_run     = 1'b0;
         hold_left      = '0;
         hold_run       = 1'b0;
         pulse_on       = 1'b0;
         held_ticks     = '0;
         rsp_count      = 0;
         mismatch_count = 0;
         expected_events.delete();
         outstanding   <= 0;
      end else begin
         // compare a response word with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got.ev        = bdlp_pkg::event_type'(rsp_tuser);
            got.held      = rsp_tdata[bdlp_pkg::HELD_W-1:0];
            got.drive_en  = rsp_tdata[bdlp_pkg::HELD_W];
            got.drive_lvl = rsp_tdata[bdlp_pkg::HELD_W+1];
            if (expected_events.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response word %0d arrived with none expected (event %0d)",
                           $realtime, rsp_count, rsp_tuser);
            end else begin
               want = expected_events.pop_front();
               if (got.ev !== want.ev || got.held !== want.held ||
                   got.drive_en !== want.drive_en || got.drive_lvl !== want.drive_lvl) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display(
                        "%0t: rsp %0d exp ev %0d dur %0d drv %b%b, got ev %0d dur %0d drv %b%b",
                        $realtime, rsp_count, want.ev, want.held, want.drive_en,
                        want.drive_lvl, rsp_tuser, got.held, got.drive_en, got.drive_lvl);
               end
            end
            rsp_count++;
         end
         // track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bdlp_pkg::REG_DEBOUNCE:
                  debounce_cfg  = csr_data[bdlp_pkg::DEBOUNCE_W-1:0];
               bdlp_pkg::REG_LONGPRESS:
                  longpress_cfg = csr_data[bdlp_pkg::LONGPRESS_W-1:0];
               bdlp_pkg::REG_ACTIVE_LEVEL:
                  active_cfg    = csr_data[0];
               default: ;
            endcase
         end
         // predict the response for an accepted request word
         if (req_tvalid && req_tready)
            expected_events.push_back(predict_button_step(bdlp_pkg::func_type'(req_tuser),
                                                          req_tdata[0],
                                                          req_tdata[bdlp_pkg::PULSE_W:1]));
         outstanding <= expected_events.size();
      end
   end

endmodule

FILE: verif/tb_top.sv
// Top of the button core testbench: clock, reset, stimulus and the final verdict.
// Drives button_debounce_longpress_pulse_core and checks it with bdlp_event_checker;
// needs bdlp_pkg for the word layout, request kinds and register indexes.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bdlp_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;   // [0] pin_level, [16:1] pulse_ms
   logic                             req_tuser  = 1'b0; // [0] func
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bdlp_pkg::RSP_TDATA_W-1:0] rsp_tdata;         // [31:0] press_duration,
                                                        // [32] drive_enable,
                                                        // [33] drive_level
   logic [bdlp_pkg::RSP_TUSER_W-1:0] rsp_tuser;         // [1:0] event_code
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [bdlp_pkg::CSR_IDX_W-1:0]   csr_index  = '0;
   logic [bdlp_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   int mismatch_count;
   int outstanding;
   int words_sent  = 0;
   bit sender_calm = 1'b0;
   bit rsp_calm    = 1'b0;
   int stall_left  = 0;

   // register settings per random phase; the last one is drawn at random
   logic [15:0] phase_deb  [6] = '{16'd2, 16'h0400, 16'hFFFF, 16'd1, 16'd5, 16'd0};
   logic [15:0] phase_long [6] = '{16'd3, 16'd0,    16'hFFFF, 16'd1, 16'd9, 16'd0};
   logic        phase_act  [6] = '{1'b1,  1'b0,     1'b1,     1'b0,  1'b1,  1'b0};
   int          phase_len  [6] = '{160,   140,      40,       150,   180,   180};

   button_debounce_longpress_pulse_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bdlp_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // stall the response side: mostly short stalls, a few long, calm stretches between
   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0)
         rsp_calm = !rsp_calm;
      if (stall_left == 0 && !rsp_calm && $urandom_range(0, 3) == 0)
         stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (sender_calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] pick_pulse_len();
      if ($urandom_range(0, 19) == 0)
         return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 12));
   endfunction

   // Send one request word, after a random gap, and hold it until accepted.
   task automatic send_word(bdlp_pkg::func_type f, logic lvl, logic [15:0] plen);
      int gap;
      if ($urandom_range(0, 99) == 0)
         sender_calm = !sender_calm;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {7'd0, plen, lvl};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Hold off the sender until every expected response word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(bdlp_pkg::reg_idx_type idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Reprogram all registers once the block has gone quiet.
   task automatic apply_settings(logic [15:0] deb, logic [15:0] lng, logic act);
      wait_drained();
      repeat (3) @(posedge clock);
      write_reg(bdlp_pkg::REG_DEBOUNCE, deb);
      write_reg(bdlp_pkg::REG_LONGPRESS, lng);
      write_reg(bdlp_pkg::REG_ACTIVE_LEVEL, {15'd0, act});
      write_reg(bdlp_pkg::REG_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // One button action: some bounce, then a steady level, with the odd pulse request.
   task automatic button_session(int cap, int phase_end);
      int   bounces;
      int   hold;
      int   k;
      logic target;
      target  = 1'($urandom_range(0, 1));
      bounces = $urandom_range(0, 3);
      for (k = 0; k < bounces && words_sent < phase_end; k++)
         send_word(bdlp_pkg::FUNC_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
      hold = $urandom_range(1, cap);
      for (k = 0; k < hold && words_sent < phase_end; k++) begin
         if ($urandom_range(0, 15) == 0)
            send_word(bdlp_pkg::FUNC_PULSE, 1'($urandom_range(0, 1)), pick_pulse_len());
         else
            send_word(bdlp_pkg::FUNC_TICK, target, 16'($urandom));
      end
   endtask

   initial begin
      int          phase;
      int          phase_end;
      int          r;
      int          cap;
      logic [15:0] deb_val;
      logic [15:0] long_val;
      logic        act_val;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero-length pulse, maximum pulse, retrigger of an active pulse
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_PULSE, 1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'hFFFF);
      send_word(bdlp_pkg::FUNC_PULSE, 1'b0, 16'hFFFF);
      send_word(bdlp_pkg::FUNC_PULSE, 1'b0, 16'd1);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);

      // short timers: press, repeated long press, bounce, release, pulses around edges
      apply_settings(16'd1, 16'd2, 1'b1);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_PULSE, 1'b1, 16'd3);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_PULSE, 1'b0, 16'd5);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b0, 16'd0);
      send_word(bdlp_pkg::FUNC_TICK,  1'b1, 16'd0);

      // random phases, each under its own register settings
      for (phase = 0; phase < 6; phase++) begin
         deb_val  = phase_deb[phase];
         long_val = phase_long[phase];
         act_val  = phase_act[phase];
         if (phase == 5) begin
            deb_val  = 16'($urandom_range(1, 6));
            long_val = 16'($urandom_range(1, 15));
            act_val  = 1'($urandom_range(0, 1));
         end
         apply_settings(deb_val, long_val, act_val);
         cap = int'(deb_val[bdlp_pkg::DEBOUNCE_W-1:0]) + 3 * int'(long_val) + 3;
         if (cap > 400)
            cap = 60;
         phase_end = words_sent + phase_len[phase];
         while (words_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               // noise: any kind, any level, any length
               repeat ($urandom_range(1, 4))
                  send_word(bdlp_pkg::func_type'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 16'($urandom));
            end else if (r < 14) begin
               wait_drained();
            end else begin
               button_session(cap, phase_end);
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
